// ===== rtl/fhd_pkg.sv =====
// Shared types and constants for the frame header deframer.
// Holds the result record, the write request into the result queue and the codes.
// No dependencies; compile first.
package fhd_pkg;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [4:0] HDR_LEN     = 5'd20;
    localparam logic [7:0] HDR_VERSION = 8'd1;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_HDR_BAD  = 2'd1;
    localparam logic [1:0] ST_CSUM_BAD = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_DROP    = 3'b100
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [15:0] service_id;
        logic [15:0] message_type;
        logic [31:0] payload_length;
        logic        payload_big_endian;
        logic [1:0]  status;
        logic        last;
    } t_result;

    // Up to two results per input transaction; second only together with first.
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

// ===== rtl/fhd_in_if.sv =====
// Input channel of the frame header deframer: valid/ready, an action bit and one frame byte.
// Depends on nothing.
interface fhd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

// ===== rtl/fhd_out_if.sv =====
// Result channel of the frame header deframer: valid/ready plus one result record.
// Depends on nothing.
interface fhd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] service_id;
    logic [15:0] message_type;
    logic [31:0] payload_length;
    logic        payload_big_endian;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output kind, output payload_byte, output service_id,
                    output message_type, output payload_length,
                    output payload_big_endian, output status, output last, input ready);
    modport sink   (input valid, input kind, input payload_byte, input service_id,
                    input message_type, input payload_length,
                    input payload_big_endian, input status, input last, output ready);
endinterface

// ===== rtl/fhd_res_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on fhd_pkg and fhd_out_if.
module fhd_res_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fhd_pkg::t_push i_push,
    output logic          o_room,
    fhd_out_if.source     o_out
);
    import fhd_pkg::*;

    t_result              r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [RES_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [RES_CNT_W-1:0] r_count, n_count;
    logic [RES_CNT_W-1:0] w_push_cnt;
    logic                 w_pop;
    t_result              w_head;

    assign w_pop      = o_out.valid && o_out.ready;
    assign w_push_cnt = RES_CNT_W'(i_push.v0) + RES_CNT_W'(i_push.v1);
    assign o_room     = r_count <= RES_CNT_W'(RES_DEPTH - 2);

    always_comb begin
        n_wr_ptr = r_wr_ptr + RES_PTR_W'(w_push_cnt);
        n_rd_ptr = r_rd_ptr + RES_PTR_W'(w_pop);
        n_count  = r_count + w_push_cnt - RES_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[r_wr_ptr + RES_PTR_W'(1)] <= i_push.r1;
        end
    end

    assign w_head = r_mem[r_rd_ptr];

    assign o_out.valid              = r_count != '0;
    assign o_out.kind               = w_head.kind;
    assign o_out.payload_byte       = w_head.payload_byte;
    assign o_out.service_id         = w_head.service_id;
    assign o_out.message_type       = w_head.message_type;
    assign o_out.payload_length     = w_head.payload_length;
    assign o_out.payload_big_endian = w_head.payload_big_endian;
    assign o_out.status             = w_head.status;
    assign o_out.last               = w_head.last;

endmodule

// ===== rtl/frame_header_deframer.sv =====
// Frame header deframer top level: header parse, payload pass-through, verdicts.
// Depends on fhd_pkg, fhd_in_if, fhd_out_if and fhd_res_fifo.
//
// Usage:
//   i_in carries one frame byte per transaction (action 0) or a frame
//   boundary / abort (action 1). The first 20 bytes of a frame form a
//   little-endian header; after a good header, payload_length bytes follow
//   and are forwarded one result each on o_out.
//   o_out carries results: a header verdict, payload bytes and a frame end
//   verdict (ok, checksum mismatch or truncated). last marks the final result
//   of a frame. A bad header yields one verdict with last set, then bytes are
//   dropped until a boundary.
// Timing:
//   Each accepted byte is handled in the cycle it is accepted; its results
//   are written into a 4-entry result queue whose head drives o_out. One
//   byte per cycle is taken while the queue has room. A byte that ends a
//   good frame yields two results, while o_out hands out one per
//   transaction. i_in.ready is high while the queue has room for two results,
//   so it falls when o_out stalls or two-result bytes fill the queue.
// Reset:
//   Synchronous active-low i_rst_n empties the queue and returns the parser
//   to waiting for the first header byte.
module frame_header_deframer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fhd_in_if.sink    i_in,
    fhd_out_if.source o_out
);
    import fhd_pkg::*;

    // Header byte offsets with a meaning of their own
    localparam logic [4:0] OFS_VERSION = 5'd0;
    localparam logic [4:0] OFS_SIZE    = 5'd1;
    localparam logic [4:0] OFS_ENDIAN  = 5'd2;
    localparam logic [4:0] OFS_SVC_LO  = 5'd4;
    localparam logic [4:0] OFS_SVC_HI  = 5'd5;
    localparam logic [4:0] OFS_TYPE_LO = 5'd6;
    localparam logic [4:0] OFS_TYPE_HI = 5'd7;
    localparam logic [4:0] OFS_LEN_B0  = 5'd8;
    localparam logic [4:0] OFS_LEN_B1  = 5'd9;
    localparam logic [4:0] OFS_LEN_B2  = 5'd10;
    localparam logic [4:0] OFS_LEN_B3  = 5'd11;
    localparam logic [4:0] OFS_HDR_SUM = 5'd16;
    localparam logic [4:0] OFS_PLD_SUM = 5'd17;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_hdr_index, n_hdr_index;
    logic [7:0]  r_hdr_xor, n_hdr_xor;
    logic        r_hdr_fault, n_hdr_fault;
    logic [15:0] r_service, n_service;
    logic [15:0] r_type, n_type;
    logic [31:0] r_length, n_length;
    logic        r_endian, n_endian;
    logic [7:0]  r_exp_xor, n_exp_xor;
    logic [31:0] r_remaining, n_remaining;
    logic [7:0]  r_pld_xor, n_pld_xor;

    logic        w_accept;
    logic        w_room;
    logic        w_hdr_zero;
    logic [4:0]  w_idx;
    logic [4:0]  w_idx_next;
    logic [7:0]  w_byte;
    t_push       w_push;

    assign i_in.ready = w_room;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_byte     = i_in.data_byte;

    always_comb begin
        n_phase     = r_phase;
        n_hdr_index = r_hdr_index;
        n_hdr_xor   = r_hdr_xor;
        n_hdr_fault = r_hdr_fault;
        n_service   = r_service;
        n_type      = r_type;
        n_length    = r_length;
        n_endian    = r_endian;
        n_exp_xor   = r_exp_xor;
        n_remaining = r_remaining;
        n_pld_xor   = r_pld_xor;
        w_push      = '0;
        w_hdr_zero  = 1'b0;
        w_idx       = (r_hdr_index >= HDR_LEN) ? 5'd0 : r_hdr_index;
        w_idx_next  = w_idx + 5'd1;

        if (w_accept) begin
            if (i_in.action) begin
                // Boundary: report truncation if a frame was open, then rearm
                if (r_phase == PH_PAYLOAD) begin
                    w_push.v0        = 1'b1;
                    w_push.r0.kind   = KIND_END;
                    w_push.r0.status = ST_TRUNC;
                    w_push.r0.last   = 1'b1;
                end else if (r_phase != PH_DROP && r_hdr_index != 5'd0) begin
                    w_push.v0        = 1'b1;
                    w_push.r0.kind   = KIND_END;
                    w_push.r0.status = ST_TRUNC;
                    w_push.r0.last   = 1'b1;
                    w_hdr_zero       = 1'b1;
                end
                n_phase     = PH_HEADER;
                n_hdr_index = 5'd0;
            end else begin
                case (r_phase)
                    PH_DROP: begin
                        // drop the byte silently
                    end
                    PH_PAYLOAD: begin
                        n_pld_xor              = r_pld_xor ^ w_byte;
                        n_remaining            = r_remaining - 32'd1;
                        w_push.v0              = 1'b1;
                        w_push.r0.kind         = KIND_PAYLOAD;
                        w_push.r0.payload_byte = w_byte;
                        if (n_remaining == 32'd0) begin
                            w_push.v1        = 1'b1;
                            w_push.r1.kind   = KIND_END;
                            w_push.r1.status = (n_pld_xor == r_exp_xor) ? ST_OK : ST_CSUM_BAD;
                            w_push.r1.last   = 1'b1;
                            n_phase          = PH_HEADER;
                            n_hdr_index      = 5'd0;
                        end
                    end
                    default: begin
                        n_phase = PH_HEADER;
                        // First header byte starts from clean header registers
                        if (w_idx == 5'd0) begin
                            n_hdr_xor   = 8'd0;
                            n_hdr_fault = 1'b0;
                            n_service   = 16'd0;
                            n_type      = 16'd0;
                            n_length    = 32'd0;
                            n_endian    = 1'b0;
                            n_exp_xor   = 8'd0;
                        end
                        n_hdr_xor = n_hdr_xor ^ w_byte;
                        case (w_idx)
                            OFS_VERSION: if (w_byte != HDR_VERSION) n_hdr_fault = 1'b1;
                            OFS_SIZE:    if (w_byte != 8'(HDR_LEN)) n_hdr_fault = 1'b1;
                            OFS_ENDIAN:  n_endian = |w_byte;
                            OFS_SVC_LO:  n_service[7:0]  = n_service[7:0] | w_byte;
                            OFS_SVC_HI:  n_service[15:8] = n_service[15:8] | w_byte;
                            OFS_TYPE_LO: n_type[7:0]     = n_type[7:0] | w_byte;
                            OFS_TYPE_HI: n_type[15:8]    = n_type[15:8] | w_byte;
                            OFS_LEN_B0:  n_length[7:0]   = n_length[7:0] | w_byte;
                            OFS_LEN_B1:  n_length[15:8]  = n_length[15:8] | w_byte;
                            OFS_LEN_B2:  n_length[23:16] = n_length[23:16] | w_byte;
                            OFS_LEN_B3:  n_length[31:24] = n_length[31:24] | w_byte;
                            OFS_HDR_SUM: begin
                                // covered by the running XOR
                            end
                            OFS_PLD_SUM: n_exp_xor = w_byte;
                            // flags and reserved bytes must be zero
                            default:     if (w_byte != 8'd0) n_hdr_fault = 1'b1;
                        endcase

                        if (w_idx_next == HDR_LEN) begin
                            n_hdr_index    = 5'd0;
                            w_push.v0      = 1'b1;
                            w_push.r0.kind = KIND_HEADER;
                            if (n_hdr_fault || n_hdr_xor != 8'd0) begin
                                w_push.r0.status = ST_HDR_BAD;
                                w_push.r0.last   = 1'b1;
                                n_phase          = PH_DROP;
                            end else begin
                                n_pld_xor        = 8'd0;
                                n_remaining      = n_length;
                                w_push.r0.status = ST_OK;
                                if (n_length == 32'd0) begin
                                    // Empty payload closes the frame at once
                                    w_push.v1        = 1'b1;
                                    w_push.r1.kind   = KIND_END;
                                    w_push.r1.status = (n_exp_xor == 8'd0) ? ST_OK : ST_CSUM_BAD;
                                    w_push.r1.last   = 1'b1;
                                    n_phase          = PH_HEADER;
                                end else begin
                                    n_phase = PH_PAYLOAD;
                                end
                            end
                        end else begin
                            n_hdr_index = w_idx_next;
                        end
                    end
                endcase
            end
        end

        // Results carry the header registers after this byte, bar a header truncation
        w_push.r0.service_id         = w_hdr_zero ? 16'd0 : n_service;
        w_push.r0.message_type       = w_hdr_zero ? 16'd0 : n_type;
        w_push.r0.payload_length     = w_hdr_zero ? 32'd0 : n_length;
        w_push.r0.payload_big_endian = w_hdr_zero ? 1'b0 : n_endian;
        w_push.r1.service_id         = n_service;
        w_push.r1.message_type       = n_type;
        w_push.r1.payload_length     = n_length;
        w_push.r1.payload_big_endian = n_endian;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_index <= 5'd0;
            r_hdr_xor   <= 8'd0;
            r_hdr_fault <= 1'b0;
            r_service   <= 16'd0;
            r_type      <= 16'd0;
            r_length    <= 32'd0;
            r_endian    <= 1'b0;
            r_exp_xor   <= 8'd0;
            r_remaining <= 32'd0;
            r_pld_xor   <= 8'd0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_index <= n_hdr_index;
            r_hdr_xor   <= n_hdr_xor;
            r_hdr_fault <= n_hdr_fault;
            r_service   <= n_service;
            r_type      <= n_type;
            r_length    <= n_length;
            r_endian    <= n_endian;
            r_exp_xor   <= n_exp_xor;
            r_remaining <= n_remaining;
            r_pld_xor   <= n_pld_xor;
        end
    end

    fhd_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_out   (o_out)
    );

    // Reset rearms the header parser
    a_reset_rearm: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_phase == PH_HEADER && r_hdr_index == 5'd0))
        else $error("parser not rearmed after reset");

    // A second result only ever closes a frame
    a_second_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.v1 |-> (w_push.v0 && w_push.r1.kind == KIND_END && w_push.r1.last))
        else $error("second result is not a frame end verdict");

    // Bytes while dropping produce nothing
    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_in.action && r_phase == PH_DROP) |-> !w_push.v0)
        else $error("result produced while dropping");

    // While in payload the header index stays at zero and payload bytes remain
    a_payload_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_hdr_index == 5'd0 && r_remaining != 32'd0))
        else $error("payload phase with stale header index or empty count");

endmodule

// ===== verif/frame_header_deframer_test.sv =====
// Testbench for frame_header_deframer: random and directed byte streams, checked against
// an in-bench model of the header parser, payload pass-through and frame verdicts.
// Depends on fhd_pkg, fhd_in_if, fhd_out_if and the deframer RTL.
module frame_header_deframer_test;
    import fhd_pkg::*;

    // Input actions.
    localparam bit ACT_BYTE     = 1'b0;
    localparam bit ACT_BOUNDARY = 1'b1;

    // Header byte offsets; everything not named here must be zero.
    localparam int OFS_VERSION = 0;
    localparam int OFS_SIZE    = 1;
    localparam int OFS_ENDIAN  = 2;
    localparam int OFS_SVC     = 4;
    localparam int OFS_TYPE    = 6;
    localparam int OFS_LEN     = 8;
    localparam int OFS_HCSUM   = 16;
    localparam int OFS_PCSUM   = 17;
    localparam int HDR_BYTES   = 20;

    localparam int MAX_BODY     = 64;      // payload bytes generated per frame at most
    localparam int PHASE_ITEMS  = 240;     // effective input transactions per idle profile
    localparam int DRAIN_CYCLES = 16;      // well past a drain of the 4-entry result queue
    localparam int CYCLE_LIMIT  = 100000;

    typedef enum int {
        FAULT_NONE,
        FAULT_VERSION,
        FAULT_SIZE,
        FAULT_RESERVED,
        FAULT_HCSUM
    } hdr_fault_e;

    // Tracks the deframer state, predicts the results of each accepted transaction
    // and matches the results leaving the block against them in order.
    class frame_tracker;
        t_phase      phase;
        logic [4:0]  hdr_idx;
        logic [7:0]  hdr_xor;
        bit          hdr_fault;
        logic [15:0] svc;
        logic [15:0] mtype;
        logic [31:0] plen;
        bit          big_end;
        logic [7:0]  want_psum;
        logic [31:0] remaining;
        logic [7:0]  psum;
        t_result     pending[$];
        int          counted;
        int          errors;

        function new();
            phase     = PH_HEADER;
            hdr_idx   = '0;
            hdr_xor   = '0;
            hdr_fault = 1'b0;
            svc       = '0;
            mtype     = '0;
            plen      = '0;
            big_end   = 1'b0;
            want_psum = '0;
            remaining = '0;
            psum      = '0;
            counted   = 0;
            errors    = 0;
        endfunction

        function t_result verdict(logic [1:0] kind, logic [7:0] b, logic [1:0] st, bit last,
                                  bit with_hdr);
            t_result r;
            r.kind               = kind;
            r.payload_byte       = b;
            r.service_id         = with_hdr ? svc : '0;
            r.message_type       = with_hdr ? mtype : '0;
            r.payload_length     = with_hdr ? plen : '0;
            r.payload_big_endian = with_hdr ? big_end : 1'b0;
            r.status             = st;
            r.last               = last;
            return r;
        endfunction

        function void take_item(bit act, logic [7:0] b);
            if (act == ACT_BOUNDARY) begin
                if (phase != PH_HEADER || hdr_idx != 0)
                    counted++;
                if (phase == PH_PAYLOAD)
                    pending.push_back(verdict(KIND_END, '0, ST_TRUNC, 1'b1, 1'b1));
                else if (phase == PH_HEADER && hdr_idx != 0)
                    pending.push_back(verdict(KIND_END, '0, ST_TRUNC, 1'b1, 1'b0));
                phase   = PH_HEADER;
                hdr_idx = '0;
                return;
            end
            if (phase == PH_DROP)
                return;
            counted++;
            if (phase == PH_PAYLOAD) begin
                psum      ^= b;
                remaining -= 1;
                pending.push_back(verdict(KIND_PAYLOAD, b, ST_OK, 1'b0, 1'b1));
                if (remaining == 0) begin
                    pending.push_back(verdict(KIND_END, '0,
                                              (psum == want_psum) ? ST_OK : ST_CSUM_BAD,
                                              1'b1, 1'b1));
                    phase   = PH_HEADER;
                    hdr_idx = '0;
                end
                return;
            end
            // Collecting the header: clear the header registers on its first byte.
            if (hdr_idx == 0) begin
                hdr_xor   = '0;
                hdr_fault = 1'b0;
                svc       = '0;
                mtype     = '0;
                plen      = '0;
                big_end   = 1'b0;
                want_psum = '0;
            end
            hdr_xor ^= b;
            case (hdr_idx)
                OFS_VERSION: if (b != HDR_VERSION) hdr_fault = 1'b1;
                OFS_SIZE: if (b != {3'b000, HDR_LEN}) hdr_fault = 1'b1;
                OFS_ENDIAN: big_end = (b != 8'h00);
                OFS_SVC: svc[7:0] = b;
                OFS_SVC + 1: svc[15:8] = b;
                OFS_TYPE: mtype[7:0] = b;
                OFS_TYPE + 1: mtype[15:8] = b;
                OFS_LEN, OFS_LEN + 1, OFS_LEN + 2, OFS_LEN + 3:
                    plen[8 * (hdr_idx - OFS_LEN) +: 8] = b;
                OFS_HCSUM: ;
                OFS_PCSUM: want_psum = b;
                default: if (b != 8'h00) hdr_fault = 1'b1;
            endcase
            hdr_idx++;
            if (hdr_idx < HDR_LEN)
                return;
            hdr_idx = '0;
            if (hdr_fault || hdr_xor != 8'h00) begin
                pending.push_back(verdict(KIND_HEADER, '0, ST_HDR_BAD, 1'b1, 1'b1));
                phase = PH_DROP;
                return;
            end
            psum      = '0;
            remaining = plen;
            pending.push_back(verdict(KIND_HEADER, '0, ST_OK, 1'b0, 1'b1));
            if (plen == 0)
                pending.push_back(verdict(KIND_END, '0,
                                          (psum == want_psum) ? ST_OK : ST_CSUM_BAD,
                                          1'b1, 1'b1));
            else
                phase = PH_PAYLOAD;
        endfunction

        function string show(t_result r);
            return $sformatf(
                "kind=%0d byte=%02h svc=%04h type=%04h len=%08h be=%0d st=%0d last=%0d",
                r.kind, r.payload_byte, r.service_id, r.message_type,
                r.payload_length, r.payload_big_endian, r.status, r.last);
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function void match_result(t_result got);
            t_result want;
            string   bad;
            if (pending.size() == 0) begin
                note_error($sformatf("unexpected result %s", show(got)));
                return;
            end
            want = pending.pop_front();
            bad  = "";
            if (got.kind !== want.kind) bad = {bad, " kind"};
            if (got.payload_byte !== want.payload_byte) bad = {bad, " payload_byte"};
            if (got.service_id !== want.service_id) bad = {bad, " service_id"};
            if (got.message_type !== want.message_type) bad = {bad, " message_type"};
            if (got.payload_length !== want.payload_length) bad = {bad, " payload_length"};
            if (got.payload_big_endian !== want.payload_big_endian)
                bad = {bad, " payload_big_endian"};
            if (got.status !== want.status) bad = {bad, " status"};
            if (got.last !== want.last) bad = {bad, " last"};
            if (bad != "")
                note_error($sformatf("mismatch in%s: expected %s, got %s",
                                     bad, show(want), show(got)));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    fhd_in_if  in_ch();
    fhd_out_if res_ch();

    frame_header_deframer u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch)
    );

    frame_tracker tracker = new();
    t_result      seen_result;
    int           send_idle_pct;
    int           recv_stall_pct;
    int unsigned  cycle_count = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold the run to a bound; a hang or lost result ends here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: stall at random on the falling edge, per the current profile.
    always @(negedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Check each result transaction at the rising edge it is taken.
    always @(posedge clk) begin
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            seen_result.kind               = res_ch.kind;
            seen_result.payload_byte       = res_ch.payload_byte;
            seen_result.service_id         = res_ch.service_id;
            seen_result.message_type       = res_ch.message_type;
            seen_result.payload_length     = res_ch.payload_length;
            seen_result.payload_big_endian = res_ch.payload_big_endian;
            seen_result.status             = res_ch.status;
            seen_result.last               = res_ch.last;
            tracker.match_result(seen_result);
        end
    end

    // Drive one input transaction: idle at random first, then hold it until ready.
    task automatic send_item(bit act, logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.data_byte <= b;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        tracker.take_item(act, b);
    endtask

    // Build one frame and send it. A nonnegative cut sends only that many bytes
    // and then a boundary. A faulty header is followed by a few dropped bytes
    // and the boundary that resyncs the parser.
    task automatic send_frame(logic [15:0] svc, logic [15:0] mtype, logic [31:0] len,
                              logic [7:0] endian_b, hdr_fault_e fault, bit bad_psum,
                              int cut);
        logic [7:0] hdr[HDR_BYTES];
        logic [7:0] body[$];
        logic [7:0] csum;
        logic [7:0] mask;
        int         rsv[7];
        int         n_body;
        int         total;
        int         pos;
        int         idx;
        rsv    = '{3, 12, 13, 14, 15, 18, 19};
        n_body = (len > MAX_BODY) ? MAX_BODY : int'(len);
        repeat (n_body)
            body.push_back(8'($urandom_range(0, 255)));
        foreach (hdr[i])
            hdr[i] = 8'h00;
        hdr[OFS_VERSION]  = HDR_VERSION;
        hdr[OFS_SIZE]     = {3'b000, HDR_LEN};
        hdr[OFS_ENDIAN]   = endian_b;
        hdr[OFS_SVC]      = svc[7:0];
        hdr[OFS_SVC + 1]  = svc[15:8];
        hdr[OFS_TYPE]     = mtype[7:0];
        hdr[OFS_TYPE + 1] = mtype[15:8];
        for (int i = 0; i < 4; i++)
            hdr[OFS_LEN + i] = len[8 * i +: 8];
        csum = 8'h00;
        foreach (body[i])
            csum ^= body[i];
        if (bad_psum)
            csum ^= 8'($urandom_range(1, 255));
        hdr[OFS_PCSUM] = csum;
        csum = 8'h00;
        foreach (hdr[i])
            csum ^= hdr[i];
        hdr[OFS_HCSUM] = csum;

        // Corrupt one byte; for a field fault, fix the checksum half the time so
        // that the field check alone has to catch it.
        if (fault != FAULT_NONE) begin
            mask = 8'($urandom_range(1, 255));
            case (fault)
                FAULT_VERSION:  idx = OFS_VERSION;
                FAULT_SIZE:     idx = OFS_SIZE;
                FAULT_RESERVED: idx = rsv[$urandom_range(0, 6)];
                default:        idx = OFS_HCSUM;
            endcase
            hdr[idx] ^= mask;
            if (fault != FAULT_HCSUM && $urandom_range(0, 1) == 1)
                hdr[OFS_HCSUM] ^= mask;
        end

        total = HDR_BYTES + ((fault == FAULT_NONE) ? n_body : 0);
        for (pos = 0; pos < total && (cut < 0 || pos < cut); pos++)
            send_item(ACT_BYTE, (pos < HDR_BYTES) ? hdr[pos] : body[pos - HDR_BYTES]);
        if (cut >= 0)
            send_item(ACT_BOUNDARY, 8'($urandom_range(0, 255)));
        if (fault != FAULT_NONE) begin
            repeat ($urandom_range(0, 4))
                send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
            send_item(ACT_BOUNDARY, 8'($urandom_range(0, 255)));
        end
    endtask

    function automatic logic [7:0] pick_endian();
        return ($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom_range(1, 255));
    endfunction

    // One random stretch of traffic: mostly well-formed frames, some truncated,
    // some with bad headers, and a little raw noise.
    task automatic send_random_segment();
        int          pick;
        int          body_cap;
        logic [31:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_BODY)
                                              : $urandom_range(0, 12);
            send_frame(16'($urandom()), 16'($urandom()), len, pick_endian(), FAULT_NONE,
                       $urandom_range(0, 3) == 0, -1);
            // Drop in an idle boundary now and then; otherwise frames go back to back.
            if ($urandom_range(0, 2) == 0)
                send_item(ACT_BOUNDARY, 8'($urandom_range(0, 255)));
        end else if (pick < 70) begin
            len      = ($urandom_range(0, 1) == 1) ? $urandom() : $urandom_range(0, 12);
            body_cap = (len > MAX_BODY) ? MAX_BODY : int'(len);
            send_frame(16'($urandom()), 16'($urandom()), len, pick_endian(), FAULT_NONE,
                       $urandom_range(0, 1) == 1,
                       $urandom_range(1, HDR_BYTES - 1 + body_cap));
        end else if (pick < 88) begin
            send_frame(16'($urandom()), 16'($urandom()), $urandom(), pick_endian(),
                       hdr_fault_e'($urandom_range(FAULT_VERSION, FAULT_HCSUM)),
                       $urandom_range(0, 1) == 1, -1);
        end else begin
            repeat ($urandom_range(1, 6))
                send_item($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
            send_item(ACT_BOUNDARY, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.action    = ACT_BYTE;
        in_ch.data_byte = 8'h00;
        send_idle_pct   = 17;
        recv_stall_pct  = 60;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: boundary while idle, truncation inside the header (zero header
        // fields), then an extreme header with zero length and a bad payload checksum.
        send_item(ACT_BOUNDARY, 8'hFF);
        send_item(ACT_BYTE, HDR_VERSION);
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_BOUNDARY, 8'h00);
        send_frame(16'hFFFF, 16'h0000, 32'd0, 8'hFF, FAULT_NONE, 1'b1, -1);

        // Random traffic under three idle profiles: sender light and receiver heavy,
        // then the reverse, then both at full rate.
        while (tracker.counted < PHASE_ITEMS)
            send_random_segment();
        send_idle_pct  = 60;
        recv_stall_pct = 17;
        while (tracker.counted < 2 * PHASE_ITEMS)
            send_random_segment();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (tracker.counted < 3 * PHASE_ITEMS)
            send_random_segment();

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        // Wait out the queue so that any stray extra result is caught.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
